// File: rtl/rshe_pkg.sv
// Shared types and constants for the real spherical harmonic evaluator.
// Command and status structs between rshe_ctrl and rshe_dpath, CORDIC arctangent table.
// No dependencies.
`default_nettype none
package rshe_pkg;

   localparam int CORDIC_STEPS = 22;

   localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
   localparam logic signed [32:0] SQRT2_Q30       = 33'sd1518500250;
   localparam logic [58:0]        INV_FOUR_PI_Q62 = 59'd366986312910250154;
   localparam logic signed [63:0] ONE_Q28         = 64'sd268435456;
   localparam logic [63:0]        MAG_LIMIT       = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] OUT_MAX         = 64'sd8388607;
   localparam logic signed [63:0] OUT_MIN         = -64'sd8388608;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CINIT_THETA,
      OP_CINIT_PHI,
      OP_CSTEP,
      OP_FOLD_THETA,
      OP_FOLD_PHI,
      OP_LEG_INIT,
      OP_MUL_LOAD,
      OP_MUL_STEP,
      OP_MUL_END,
      OP_PREV_NEG,
      OP_CUR_COPY,
      OP_CUR_FIRST,
      OP_RECUR_T,
      OP_DIV_STEP,
      OP_DIV_EXT,
      OP_RECUR_NEXT,
      OP_DEN_INIT,
      OP_DEN_STEP,
      OP_NUM_LOAD,
      OP_SQRT_LOAD,
      OP_SQRT_STEP,
      OP_OUT
   } op_type;

   // multiplier operand pairs: a * b >> shift
   typedef enum logic [2:0] {
      MS_PREV_S,
      MS_PREV_C,
      MS_CUR_C,
      MS_CUR_NRM,
      MS_V_SQRT2,
      MS_V_TRIG,
      MS_V_ONE
   } mul_src_type;

   typedef struct packed {
      op_type      op;
      mul_src_type src;
      logic [4:0]  idx;
      logic [3:0]  fa;
      logic [3:0]  fb;
      logic [2:0]  fc;
   } cmd_type;

   typedef struct packed {
      logic [2:0] band;
      logic [2:0] am;
      logic       bad;
      logic       m_zero;
      logic       q_small;
      logic       out_free;
   } status_type;

   // atan(2^-i) in units of 2^24 per turn
   function automatic logic [21:0] atan_turn(input logic [4:0] i);
      logic [21:0] v;
      case (i)
         5'd0:  v = 22'd2097152;
         5'd1:  v = 22'd1238021;
         5'd2:  v = 22'd654136;
         5'd3:  v = 22'd332050;
         5'd4:  v = 22'd166669;
         5'd5:  v = 22'd83416;
         5'd6:  v = 22'd41718;
         5'd7:  v = 22'd20860;
         5'd8:  v = 22'd10430;
         5'd9:  v = 22'd5215;
         5'd10: v = 22'd2608;
         5'd11: v = 22'd1304;
         5'd12: v = 22'd652;
         5'd13: v = 22'd326;
         5'd14: v = 22'd163;
         5'd15: v = 22'd81;
         5'd16: v = 22'd41;
         5'd17: v = 22'd20;
         5'd18: v = 22'd10;
         5'd19: v = 22'd5;
         5'd20: v = 22'd3;
         5'd21: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/real_spherical_harmonic_eval.sv
// Top level of the orthonormal real spherical harmonic evaluator Y(l,m)(theta,phi).
// Instantiates rshe_ctrl and rshe_dpath; types from rshe_pkg.
//
//  channel | dir | handshake         | payload
//  req     | in  | req_tvalid/tready | tdata[39:0]: band, order, polar_angle, azimuth_angle
//  rsp     | out | rsp_tvalid/tready | tdata[23:0]: harmonic_value; tuser: bad_request
//
// One request at a time; the time per request depends on band and order, and
// the 64-step bit-serial divider (recurrence and normalization) and the 4-pass
// multiplier account for most of it. An invalid band/order goes straight to the response.
// A new request is taken while the previous response still waits in its register.
// Synchronous active-high reset clears the sequencer and the response valid flag.
`default_nettype none
module real_spherical_harmonic_eval #(
   parameter int MAX_BAND = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // band[2:0], order[6:3], polar_angle[22:7],
                                        // azimuth_angle[38:23], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // harmonic_value[23:0]
   output logic             rsp_tuser   // bad_request
);

   rshe_pkg::cmd_type    cmd;
   rshe_pkg::status_type status;

   rshe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rshe_dpath #(
      .MAX_BAND (MAX_BAND)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .band          (req_tdata[2:0]),
      .order         (req_tdata[6:3]),
      .polar_angle   (req_tdata[22:7]),
      .azimuth_angle (req_tdata[38:23]),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_value     (rsp_tdata),
      .rsp_bad       (rsp_tuser)
   );

endmodule
`default_nettype wire

// File: rtl/rshe_ctrl.sv
// Sequencer for the spherical harmonic evaluator: issues one datapath command per cycle.
// Depends on rshe_pkg (cmd_type, status_type, op_type, mul_src_type).
`default_nettype none
module rshe_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire rshe_pkg::status_type status,
   output rshe_pkg::cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_CT, S_FT, S_LI, S_PN, S_CUR0, S_CF, S_RT, S_RD, S_RN,
      S_DEN0, S_DEN, S_NUM, S_QD, S_QX, S_QX2, S_SL, S_SS, S_TRIG, S_CP, S_FP,
      S_T2, S_T3, S_ML, S_MS, S_ME, S_OUT
   } state_type;

   state_type             state_ff, state_in, ret_ff, ret_in;
   rshe_pkg::mul_src_type msrc_ff, msrc_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [3:0]            k_ff, k_in;
   logic [3:0]            am4, l4;

   assign am4 = {1'b0, status.am};
   assign l4  = {1'b0, status.band};

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      msrc_in    = msrc_ff;
      cnt_in     = cnt_ff + 6'd1;
      k_in       = k_ff;
      req_tready = 1'b0;
      cmd.op     = rshe_pkg::OP_NONE;
      cmd.src    = msrc_ff;
      cmd.idx    = cnt_ff[4:0];
      cmd.fa     = 4'd0;
      cmd.fb     = 4'd0;
      cmd.fc     = 3'd0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = rshe_pkg::OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cnt_in = 6'd0;
            if (status.bad) begin
               state_in = S_OUT;
            end else begin
               cmd.op   = rshe_pkg::OP_CINIT_THETA;
               state_in = S_CT;
            end
         end
         S_CT: begin
            cmd.op = rshe_pkg::OP_CSTEP;
            if (cnt_ff == 6'(rshe_pkg::CORDIC_STEPS - 1)) state_in = S_FT;
         end
         S_FT: begin
            cmd.op   = rshe_pkg::OP_FOLD_THETA;
            state_in = S_LI;
         end
         S_LI: begin
            cmd.op = rshe_pkg::OP_LEG_INIT;
            k_in   = 4'd1;
            if (status.am == 3'd0) begin
               state_in = S_CUR0;
            end else begin
               msrc_in  = rshe_pkg::MS_PREV_S;
               ret_in   = S_PN;
               state_in = S_ML;
            end
         end
         S_PN: begin
            cmd.op = rshe_pkg::OP_PREV_NEG;
            cmd.fa = 4'({k_ff, 1'b0} - 5'd1);
            if (k_ff == am4) begin
               state_in = S_CUR0;
            end else begin
               k_in     = k_ff + 4'd1;
               msrc_in  = rshe_pkg::MS_PREV_S;
               ret_in   = S_PN;
               state_in = S_ML;
            end
         end
         S_CUR0: begin
            if (l4 > am4) begin
               msrc_in  = rshe_pkg::MS_PREV_C;
               ret_in   = S_CF;
               state_in = S_ML;
            end else begin
               cmd.op   = rshe_pkg::OP_CUR_COPY;
               state_in = S_DEN0;
            end
         end
         S_CF: begin
            cmd.op = rshe_pkg::OP_CUR_FIRST;
            cmd.fa = 4'({status.am, 1'b0} + 4'd1);
            k_in   = am4 + 4'd2;
            if (l4 == am4 + 4'd1) begin
               state_in = S_DEN0;
            end else begin
               msrc_in  = rshe_pkg::MS_CUR_C;
               ret_in   = S_RT;
               state_in = S_ML;
            end
         end
         S_RT: begin
            cmd.op   = rshe_pkg::OP_RECUR_T;
            cmd.fa   = 4'({k_ff, 1'b0} - 5'd1);
            cmd.fb   = 4'(k_ff + am4 - 4'd1);
            cmd.fc   = 3'(k_ff - am4);
            cnt_in   = 6'd0;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.op = rshe_pkg::OP_DIV_STEP;
            if (cnt_ff == 6'd63) state_in = S_RN;
         end
         S_RN: begin
            cmd.op = rshe_pkg::OP_RECUR_NEXT;
            if (k_ff == l4) begin
               state_in = S_DEN0;
            end else begin
               k_in     = k_ff + 4'd1;
               msrc_in  = rshe_pkg::MS_CUR_C;
               ret_in   = S_RT;
               state_in = S_ML;
            end
         end
         S_DEN0: begin
            cmd.op   = rshe_pkg::OP_DEN_INIT;
            k_in     = l4 - am4 + 4'd1;
            state_in = (status.am == 3'd0) ? S_NUM : S_DEN;
         end
         S_DEN: begin
            cmd.op = rshe_pkg::OP_DEN_STEP;
            cmd.fa = k_ff;
            k_in   = k_ff + 4'd1;
            if (k_ff == l4 + am4) state_in = S_NUM;
         end
         S_NUM: begin
            cmd.op   = rshe_pkg::OP_NUM_LOAD;
            cnt_in   = 6'd0;
            state_in = S_QD;
         end
         S_QD: begin
            cmd.op = rshe_pkg::OP_DIV_STEP;
            if (cnt_ff == 6'd63) state_in = S_QX;
         end
         S_QX: begin
            if (status.q_small) begin
               cmd.op   = rshe_pkg::OP_DIV_EXT;
               state_in = S_QX2;
            end else begin
               state_in = S_SL;
            end
         end
         S_QX2: begin
            cmd.op   = rshe_pkg::OP_DIV_EXT;
            state_in = S_QX;
         end
         S_SL: begin
            cmd.op   = rshe_pkg::OP_SQRT_LOAD;
            cnt_in   = 6'd0;
            state_in = S_SS;
         end
         S_SS: begin
            cmd.op = rshe_pkg::OP_SQRT_STEP;
            if (cnt_ff == 6'd31) begin
               msrc_in  = rshe_pkg::MS_CUR_NRM;
               ret_in   = S_TRIG;
               state_in = S_ML;
            end
         end
         S_TRIG: begin
            cnt_in = 6'd0;
            if (status.m_zero) begin
               msrc_in  = rshe_pkg::MS_V_ONE;
               ret_in   = S_OUT;
               state_in = S_ML;
            end else begin
               cmd.op   = rshe_pkg::OP_CINIT_PHI;
               state_in = S_CP;
            end
         end
         S_CP: begin
            cmd.op = rshe_pkg::OP_CSTEP;
            if (cnt_ff == 6'(rshe_pkg::CORDIC_STEPS - 1)) state_in = S_FP;
         end
         S_FP: begin
            cmd.op   = rshe_pkg::OP_FOLD_PHI;
            msrc_in  = rshe_pkg::MS_V_SQRT2;
            ret_in   = S_T2;
            state_in = S_ML;
         end
         S_T2: begin
            msrc_in  = rshe_pkg::MS_V_TRIG;
            ret_in   = S_T3;
            state_in = S_ML;
         end
         S_T3: begin
            msrc_in  = rshe_pkg::MS_V_ONE;
            ret_in   = S_OUT;
            state_in = S_ML;
         end
         S_ML: begin
            cmd.op   = rshe_pkg::OP_MUL_LOAD;
            cnt_in   = 6'd0;
            state_in = S_MS;
         end
         S_MS: begin
            cmd.op = rshe_pkg::OP_MUL_STEP;
            if (cnt_ff == 6'd3) state_in = S_ME;
         end
         S_ME: begin
            cmd.op   = rshe_pkg::OP_MUL_END;
            state_in = ret_ff;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.op   = rshe_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         msrc_ff  <= rshe_pkg::MS_V_ONE;
         cnt_ff   <= 6'd0;
         k_ff     <= 4'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         msrc_ff  <= msrc_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/rshe_dpath.sv
// Datapath: CORDIC rotator, Legendre registers, 4-pass multiplier, bit-serial divider,
// integer square root and the result register. Driven by rshe_ctrl commands.
// Depends on rshe_pkg.
`default_nettype none
module rshe_dpath #(
   parameter int MAX_BAND = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rshe_pkg::cmd_type cmd,
   input  wire logic [2:0]        band,
   input  wire logic [3:0]        order,
   input  wire logic [15:0]       polar_angle,
   input  wire logic [15:0]       azimuth_angle,
   output rshe_pkg::status_type   status,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_value,
   output logic                   rsp_bad
);

   logic [2:0]         band_ff, band_in;
   logic [3:0]         order_ff, order_in;
   logic [15:0]        theta_ff, theta_in, phi_ff, phi_in;
   logic signed [32:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [24:0] cz_ff, cz_in;
   logic [1:0]         cq_ff, cq_in;
   logic signed [32:0] c_ff, c_in, s_ff, s_in, trig_ff, trig_in;
   logic signed [63:0] prev_ff, prev_in, cur_ff, cur_in, mres_ff, mres_in;
   logic [63:0]        ma_ff, ma_in;
   logic [31:0]        mb_ff, mb_in;
   logic               mneg_ff, mneg_in;
   logic [95:0]        macc_ff, macc_in;
   logic [5:0]         msh_ff, msh_in;
   logic [63:0]        dnum_ff, dnum_in, dq_ff, dq_in;
   logic [36:0]        dden_ff, dden_in, drem_ff, drem_in;
   logic               dneg_ff, dneg_in;
   logic [36:0]        den_ff, den_in;
   logic [5:0]         e_ff, e_in;
   logic [63:0]        sop_ff, sop_in, sres_ff, sres_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_value_ff, rsp_value_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [3:0]         am4;
   logic               bad;
   logic               m_zero, m_pos;
   logic [15:0]        cangle;
   logic signed [32:0] dx, dy, co, si;
   logic signed [24:0] at_s;
   logic signed [63:0] a_sel;
   logic signed [32:0] b_sel, b_mag;
   logic [5:0]         sh_sel;
   logic [15:0]        dig;
   logic [47:0]        pp;
   logic [95:0]        mshift;
   logic [63:0]        mmag;
   logic signed [63:0] fa_w, fb_w, tval;
   logic [37:0]        rsh, rdiff;
   logic               dge;
   logic [63:0]        sbit, strial;
   logic [23:0]        clamped;

   assign am4    = order_ff[3] ? 4'(-order_ff) : order_ff;
   assign bad    = (int'(band_ff) > MAX_BAND) || (am4 > {1'b0, band_ff});
   assign m_zero = (order_ff == 4'd0);
   assign m_pos  = !order_ff[3] && !m_zero;

   assign status.band     = band_ff;
   assign status.am       = am4[2:0];
   assign status.bad      = bad;
   assign status.m_zero   = m_zero;
   assign status.q_small  = (dq_ff[63:60] == 4'd0);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // CORDIC step, floor shifts
   assign dx   = cy_ff >>> cmd.idx;
   assign dy   = cx_ff >>> cmd.idx;
   assign at_s = signed'({3'b000, rshe_pkg::atan_turn(cmd.idx)});
   assign cangle = (cmd.op == rshe_pkg::OP_CINIT_PHI) ?
                   16'({13'd0, am4[2:0]} * phi_ff) : theta_ff;

   always_comb begin
      case (cq_ff)
         2'd0: begin co = cx_ff;  si = cy_ff;  end
         2'd1: begin co = -cy_ff; si = cx_ff;  end
         2'd2: begin co = -cx_ff; si = -cy_ff; end
         default: begin co = cy_ff; si = -cx_ff; end
      endcase
   end

   // multiplier operand selection
   always_comb begin
      case (cmd.src)
         rshe_pkg::MS_PREV_S, rshe_pkg::MS_PREV_C: a_sel = prev_ff;
         rshe_pkg::MS_CUR_C, rshe_pkg::MS_CUR_NRM: a_sel = cur_ff;
         default:                                  a_sel = mres_ff;
      endcase
      case (cmd.src)
         rshe_pkg::MS_PREV_S:  b_sel = s_ff;
         rshe_pkg::MS_PREV_C:  b_sel = c_ff;
         rshe_pkg::MS_CUR_C:   b_sel = c_ff;
         rshe_pkg::MS_CUR_NRM: b_sel = signed'({1'b0, sres_ff[31:0]});
         rshe_pkg::MS_V_SQRT2: b_sel = rshe_pkg::SQRT2_Q30;
         rshe_pkg::MS_V_TRIG:  b_sel = trig_ff;
         default:              b_sel = 33'sd1;
      endcase
      case (cmd.src)
         rshe_pkg::MS_CUR_NRM: sh_sel = 6'd29 + {1'b0, e_ff[5:1]};
         rshe_pkg::MS_V_ONE:   sh_sel = 6'd10;
         default:              sh_sel = 6'd30;
      endcase
   end

   assign b_mag  = b_sel[32] ? -b_sel : b_sel;
   assign dig    = ma_ff[{cmd.idx[1:0], 4'b0000} +: 16];
   assign pp     = {32'd0, dig} * {16'd0, mb_ff};
   assign mshift = macc_ff >> msh_ff;
   assign mmag   = (|mshift[95:62]) ? rshe_pkg::MAG_LIMIT : mshift[63:0];

   // small integer factors of the recurrence
   assign fa_w = signed'({60'd0, cmd.fa});
   assign fb_w = signed'({60'd0, cmd.fb});
   assign tval = fa_w * mres_ff - fb_w * prev_ff;

   // restoring divider step
   assign rsh   = {drem_ff, dnum_ff[63]};
   assign dge   = rsh >= {1'b0, dden_ff};
   assign rdiff = rsh - {1'b0, dden_ff};

   // square root step
   assign sbit   = 64'd1 << (7'd62 - {1'b0, cmd.idx, 1'b0});
   assign strial = sres_ff + sbit;

   always_comb begin
      if (mres_ff > rshe_pkg::OUT_MAX)      clamped = 24'h7FFFFF;
      else if (mres_ff < rshe_pkg::OUT_MIN) clamped = 24'h800000;
      else                                  clamped = mres_ff[23:0];
   end

   always_comb begin
      band_in      = band_ff;
      order_in     = order_ff;
      theta_in     = theta_ff;
      phi_in       = phi_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      cq_in        = cq_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      trig_in      = trig_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      mres_in      = mres_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mneg_in      = mneg_ff;
      macc_in      = macc_ff;
      msh_in       = msh_ff;
      dnum_in      = dnum_ff;
      dq_in        = dq_ff;
      dden_in      = dden_ff;
      drem_in      = drem_ff;
      dneg_in      = dneg_ff;
      den_in       = den_ff;
      e_in         = e_ff;
      sop_in       = sop_ff;
      sres_in      = sres_ff;
      rsp_value_in = rsp_value_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (cmd.op)
         rshe_pkg::OP_LOAD: begin
            band_in  = band;
            order_in = order;
            theta_in = polar_angle;
            phi_in   = azimuth_angle;
         end
         rshe_pkg::OP_CINIT_THETA, rshe_pkg::OP_CINIT_PHI: begin
            cq_in = cangle[15:14];
            cz_in = signed'({3'b000, cangle[13:0], 8'd0});
            cx_in = rshe_pkg::CORDIC_GAIN_Q30;
            cy_in = 33'sd0;
         end
         rshe_pkg::OP_CSTEP: begin
            if (!cz_ff[24]) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - at_s;
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + at_s;
            end
         end
         rshe_pkg::OP_FOLD_THETA: begin
            c_in = co;
            s_in = si[32] ? -si : si;
         end
         rshe_pkg::OP_FOLD_PHI: trig_in = m_pos ? co : si;
         rshe_pkg::OP_LEG_INIT: prev_in = rshe_pkg::ONE_Q28;
         rshe_pkg::OP_MUL_LOAD: begin
            ma_in   = a_sel[63] ? 64'(-a_sel) : 64'(a_sel);
            mb_in   = b_mag[31:0];
            mneg_in = a_sel[63] ^ b_sel[32];
            macc_in = 96'd0;
            msh_in  = sh_sel;
         end
         rshe_pkg::OP_MUL_STEP: macc_in = macc_ff + ({48'd0, pp} << {cmd.idx[1:0], 4'b0000});
         rshe_pkg::OP_MUL_END: mres_in = mneg_ff ? -signed'(mmag) : signed'(mmag);
         rshe_pkg::OP_PREV_NEG: prev_in = -(mres_ff * fa_w);
         rshe_pkg::OP_CUR_COPY: cur_in = prev_ff;
         rshe_pkg::OP_CUR_FIRST: cur_in = mres_ff * fa_w;
         rshe_pkg::OP_RECUR_T: begin
            dnum_in = tval[63] ? 64'(-tval) : 64'(tval);
            dneg_in = tval[63];
            dden_in = {34'd0, cmd.fc};
            drem_in = 37'd0;
            dq_in   = 64'd0;
         end
         rshe_pkg::OP_DIV_STEP, rshe_pkg::OP_DIV_EXT: begin
            drem_in = dge ? rdiff[36:0] : rsh[36:0];
            dq_in   = {dq_ff[62:0], dge};
            dnum_in = {dnum_ff[62:0], 1'b0};
            if (cmd.op == rshe_pkg::OP_DIV_EXT) e_in = e_ff + 6'd1;
         end
         rshe_pkg::OP_RECUR_NEXT: begin
            prev_in = cur_ff;
            cur_in  = dneg_ff ? -signed'(dq_ff) : signed'(dq_ff);
         end
         rshe_pkg::OP_DEN_INIT: den_in = 37'd1;
         rshe_pkg::OP_DEN_STEP: den_in = 37'(den_ff * {33'd0, cmd.fa});
         rshe_pkg::OP_NUM_LOAD: begin
            dnum_in = 64'({60'd0, band_ff, 1'b1} * {5'd0, rshe_pkg::INV_FOUR_PI_Q62});
            dden_in = den_ff;
            drem_in = 37'd0;
            dq_in   = 64'd0;
            e_in    = 6'd0;
         end
         rshe_pkg::OP_SQRT_LOAD: begin
            sop_in  = dq_ff;
            sres_in = 64'd0;
         end
         rshe_pkg::OP_SQRT_STEP: begin
            if (sop_ff >= strial) begin
               sop_in  = sop_ff - strial;
               sres_in = (sres_ff >> 1) + sbit;
            end else begin
               sres_in = sres_ff >> 1;
            end
         end
         rshe_pkg::OP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_bad_in   = bad;
            rsp_value_in = bad ? 24'd0 : clamped;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      band_ff      <= band_in;
      order_ff     <= order_in;
      theta_ff     <= theta_in;
      phi_ff       <= phi_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      cq_ff        <= cq_in;
      c_ff         <= c_in;
      s_ff         <= s_in;
      trig_ff      <= trig_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      mres_ff      <= mres_in;
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      mneg_ff      <= mneg_in;
      macc_ff      <= macc_in;
      msh_ff       <= msh_in;
      dnum_ff      <= dnum_in;
      dq_ff        <= dq_in;
      dden_ff      <= dden_in;
      drem_ff      <= drem_in;
      dneg_ff      <= dneg_in;
      den_ff       <= den_in;
      e_ff         <= e_in;
      sop_ff       <= sop_in;
      sres_ff      <= sres_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_bad    = rsp_bad_ff;

endmodule
`default_nettype wire

// File: rtl/rshe_checker.sv
// Port-level checks for real_spherical_harmonic_eval, bound to the top level.
// No package dependencies.
`default_nettype none
module rshe_checker #(
   parameter int MAX_BAND = 7
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [39:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   logic [3:0] ord_mag;
   logic       req_bad;

   assign ord_mag = req_tdata[6] ? 4'(-req_tdata[6:3]) : req_tdata[6:3];
   assign req_bad = (int'(req_tdata[2:0]) > MAX_BAND) || (ord_mag > {1'b0, req_tdata[2:0]});

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("flagged response carries nonzero value");

   a_bad_fast: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_bad && !rsp_tvalid |-> ##3 rsp_tvalid && rsp_tuser)
      else $error("invalid request not answered in three cycles");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

endmodule

bind real_spherical_harmonic_eval rshe_checker #(.MAX_BAND(MAX_BAND)) u_rshe_checker (.*);
`default_nettype wire

// File: test/tb_real_spherical_harmonic_eval.sv
// Testbench for real_spherical_harmonic_eval: directed and random requests on the stream ports,
// with a fixed-point predictor of Y(l,m) in a scoreboard and random stalls on both sides.
// Depends only on the RTL of the block.
`timescale 1ns / 1ps
module tb_real_spherical_harmonic_eval;

   localparam int          RANDOM_REQUESTS = 1550;
   localparam longint      CYCLE_LIMIT     = 64'd30_000_000;
   localparam int          TAIL_CYCLES     = 40;
   localparam logic [63:0] MAG_CAP         = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam longint      GAIN_Q30        = 652032874;
   localparam longint      ROOT2_Q30       = 1518500250;
   localparam longint unsigned INV_4PI_Q62 = 64'd366986312910250154;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   longint      cycles = 0;

   typedef struct {
      logic [23:0] value;
      logic        bad;
   } harmonic_t;

   class harmonic_scoreboard;
      harmonic_t pending[$];
      int        errors = 0;

      static function automatic longint mul_trunc(longint a, longint b, int sh);
         logic [63:0]  ua, ub;
         logic [127:0] p;
         bit           neg;
         neg = (a < 0) != (b < 0);
         ua  = a < 0 ? -a : a;
         ub  = b < 0 ? -b : b;
         p   = ({64'd0, ua} * {64'd0, ub}) >> (sh & 63);
         if (p > {64'd0, MAG_CAP}) p = {64'd0, MAG_CAP};
         return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
      endfunction

      static function automatic longint unsigned root64(longint unsigned op);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > op) bitv >>= 2;
         while (bitv != 0) begin
            if (op >= res + bitv) begin
               op -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      static function automatic longint atan_step(int i);
         longint t[22] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                           10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
         return t[i];
      endfunction

      static function automatic void rotate(logic [15:0] ang, output longint co,
                                            output longint si);
         longint x, y, z, dx, dy;
         x = GAIN_Q30;
         y = 0;
         z = longint'(ang[13:0]) << 8;
         for (int i = 0; i < 22; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_step(i);
            end else begin
               x += dx; y -= dy; z += atan_step(i);
            end
         end
         case (ang[15:14])
            2'd0: begin co = x;  si = y;  end
            2'd1: begin co = -y; si = x;  end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
         endcase
      endfunction

      static function automatic longint unsigned factorial(int n);
         longint unsigned f;
         f = 1;
         for (int i = 2; i <= n; i++) f *= i;
         return f;
      endfunction

      static function automatic harmonic_t predict(logic [2:0] band, logic signed [3:0] order,
                                                   logic [15:0] theta, logic [15:0] phi);
         harmonic_t r;
         longint l, m, am, c, s, prev, cur, nxt, odd, v, tc, ts;
         longint unsigned den, num, q, rem, nrm;
         int e;
         l  = band;
         m  = order;
         am = m < 0 ? -m : m;
         r.bad = 1'b0;
         if (am > l) begin
            r.value = '0;
            r.bad   = 1'b1;
            return r;
         end
         rotate(theta, c, s);
         if (s < 0) s = -s;
         prev = 64'sd1 << 28;
         odd  = 1;
         for (longint k = 1; k <= am; k++) begin
            prev = -(mul_trunc(prev, s, 30) * odd);
            odd += 2;
         end
         cur = prev;
         if (l > am) begin
            cur = mul_trunc(prev, c, 30) * (2 * am + 1);
            for (longint k = am + 2; k <= l; k++) begin
               nxt  = ((2 * k - 1) * mul_trunc(cur, c, 30) - (k + am - 1) * prev) / (k - am);
               prev = cur;
               cur  = nxt;
            end
         end
         den = factorial(l + am) / factorial(l - am);
         num = longint'(2 * l + 1) * INV_4PI_Q62;
         q   = num / den;
         rem = num % den;
         e   = 0;
         while (q < (64'd1 << 60) && e < 120) begin
            for (int b = 0; b < 2; b++) begin
               rem <<= 1;
               q <<= 1;
               if (rem >= den) begin
                  rem -= den;
                  q |= 1;
               end
            end
            e += 2;
         end
         nrm = root64(q);
         v   = mul_trunc(cur, longint'(nrm), 31 + e / 2 - 2);
         if (m != 0) begin
            rotate(16'(am * phi), tc, ts);
            v = mul_trunc(v, ROOT2_Q30, 30);
            v = mul_trunc(v, m > 0 ? tc : ts, 30);
         end
         v = mul_trunc(v, 1, 10);
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         r.value = v[23:0];
         return r;
      endfunction

      function void note_request(logic [39:0] data);
         pending.push_back(predict(data[2:0], data[6:3], data[22:7], data[38:23]));
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(logic [23:0] value, logic bad);
         harmonic_t exp_r;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response %h/%b", value, bad));
            return;
         end
         exp_r = pending.pop_front();
         if (value !== exp_r.value)
            report($sformatf("harmonic_value %h, expected %h", value, exp_r.value));
         if (bad !== exp_r.bad)
            report($sformatf("bad_request %b, expected %b", bad, exp_r.bad));
      endtask
   endclass

   harmonic_scoreboard board = new();

   real_spherical_harmonic_eval DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(5, 120);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) board.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
   end

   int stall_left = 0;
   int calm_left  = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left  <= calm_left - 1;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 5) begin
         calm_left  <= $urandom_range(50, 2000);
         rsp_tready <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   task automatic send(logic [2:0] band, logic signed [3:0] order, logic [15:0] theta,
                       logic [15:0] phi);
      int gap;
      req_tdata  <= {1'b0, phi, theta, order, band};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(3'd0, 4'sd0, 16'h0000, 16'h0000);
      send(3'd7, 4'sd7, 16'h4000, 16'h2000);
      send(3'd7, -4'sd7, 16'h4000, 16'hE000);
      send(3'd7, 4'sd0, 16'hFFFF, 16'hFFFF);
      send(3'd7, 4'sd0, 16'h8000, 16'h0000);
      send(3'd3, 4'sd2, 16'hC000, 16'h1234);
      send(3'd5, -4'sd3, 16'h2AAA, 16'h8000);
      send(3'd1, 4'sd1, 16'h1000, 16'h4000);
      send(3'd1, -4'sd1, 16'h1000, 16'h4000);
      send(3'd0, 4'sd1, 16'h1000, 16'h4000);
      send(3'd6, -4'sd8, 16'h3000, 16'h5000);
      send(3'd2, -4'sd3, 16'hFFFF, 16'h0001);
      send(3'd7, -4'sd8, 16'h0001, 16'hFFFF);
      send(3'd4, 4'sd4, 16'h0000, 16'h8000);
      send(3'd6, 4'sd1, 16'h7FFF, 16'h7FFF);
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            b = $urandom_range(0, 7);
            send(3'(b), 4'($signed($urandom_range(0, 2 * b)) - b),
                 16'($urandom), 16'($urandom));
         end else begin
            send(3'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
